// File: rtl/gcc_pkg.sv
package gcc_pkg;

   localparam int PIX_W      = 17;
   localparam int GRAD_W     = 18;
   localparam int PROD_W     = 36;
   localparam int CORR_W     = 63;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TPL_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TPL_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT = 2'd3;

   typedef logic signed [PIX_W-1:0]  pix_type;
   typedef logic signed [GRAD_W-1:0] grad_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // One template sample and the image sample under it.
   typedef struct packed {
      pix_type tpl;
      pix_type img;
   } pair_type;

   typedef struct packed {
      logic     valid;
      logic     last;
      grad_type dx_t;
      grad_type dx_i;
      grad_type dy_t;
      grad_type dy_i;
   } grad_bundle_type;

   typedef struct packed {
      logic                     done;
      logic signed [CORR_W-1:0] sum;
   } mac_out_type;

endpackage

// File: rtl/gcc_if.sv
interface gcc_req_if;
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   gcc_pkg::pix_type      pixel_value;

   modport source (output valid, req_type, pixel_value, input ready);
   modport sink   (input valid, req_type, pixel_value, output ready);
endinterface

interface gcc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [gcc_pkg::CORR_W-1:0]    correlation;
   logic [9:0]                           offset_x;
   logic [15:0]                          offset_y;
   logic                                 frame_last;

   modport source (output valid, correlation, offset_x, offset_y, frame_last, input ready);
   modport sink   (input valid, correlation, offset_x, offset_y, frame_last, output ready);
endinterface

// File: rtl/gcc_cell.sv
// One stage of the sample delay line; moves its pair on when shift is high.
module gcc_cell (
   input  logic                clock,
   input  logic                shift,
   input  gcc_pkg::pair_type   d,
   output gcc_pkg::pair_type   q
);

   gcc_pkg::pair_type pair_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         pair_ff <= d;
      end
   end

   assign q = pair_ff;

endmodule

// File: rtl/gcc_mac.sv
// Gradient register, two products, then the running sum.
module gcc_mac (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  gcc_pkg::grad_bundle_type  grad,
   output gcc_pkg::mac_out_type      result
);

   gcc_pkg::grad_bundle_type               grad_ff;
   logic signed [gcc_pkg::PROD_W-1:0]      prod_x_ff;
   logic signed [gcc_pkg::PROD_W-1:0]      prod_y_ff;
   logic                                   prod_valid_ff;
   logic                                   prod_last_ff;
   logic signed [gcc_pkg::CORR_W-1:0]      acc_ff;
   logic signed [gcc_pkg::CORR_W-1:0]      acc_in;
   logic                                   done_ff;

   // Only the valid and done flags are reset; the data fields simply follow their inputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         grad_ff.valid <= 1'b0;
         prod_valid_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         grad_ff.valid <= grad.valid;
         prod_valid_ff <= grad_ff.valid;
         done_ff       <= prod_valid_ff && prod_last_ff;
      end
      grad_ff.last <= grad.last;
      grad_ff.dx_t <= grad.dx_t;
      grad_ff.dx_i <= grad.dx_i;
      grad_ff.dy_t <= grad.dy_t;
      grad_ff.dy_i <= grad.dy_i;
      prod_x_ff    <= grad_ff.dx_t * grad_ff.dx_i;
      prod_y_ff    <= grad_ff.dy_t * grad_ff.dy_i;
      prod_last_ff <= grad_ff.last;
   end

   always_comb begin
      acc_in = acc_ff + gcc_pkg::CORR_W'(prod_x_ff) + gcc_pkg::CORR_W'(prod_y_ff);
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign result.done = done_ff;
   assign result.sum  = acc_ff;

endmodule

// File: rtl/gradient_cross_correlator.sv
// Template requests are taken whenever the controller is idle and never produce a result.
// An image request that completes a window starts a scan of template and window; the
// controller then drains the accumulator and offers the result, and takes no new request
// until that result is in the output register. Other image requests are taken while idle.
// The scan is bounded by the single read port of the template and line memories.
// Reset (synchronous) restores 8/8/640/480, zeroes the raster counters, keeps memories.
module gradient_cross_correlator #(
   parameter int MAX_TEMPLATE_W = 16,
   parameter int MAX_TEMPLATE_H = 16,
   parameter int MAX_IMAGE_W    = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   gcc_req_if.sink                           req_if,
   gcc_rsp_if.source                         rsp_if,
   input  logic                              csr_we,
   input  logic [gcc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gcc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TCW = $clog2(MAX_TEMPLATE_W);
   localparam int TRW = $clog2(MAX_TEMPLATE_H);
   localparam int TDW = $clog2(MAX_TEMPLATE_W + 1);
   localparam int THW = $clog2(MAX_TEMPLATE_H + 1);
   localparam int TAW = $clog2(MAX_TEMPLATE_W * MAX_TEMPLATE_H);
   localparam int ICW = $clog2(MAX_IMAGE_W);
   localparam int IWW = $clog2(MAX_IMAGE_W + 1);
   localparam int IAW = $clog2(MAX_TEMPLATE_H * MAX_IMAGE_W);

   // Configuration registers, stored raw and clamped where used.
   logic [4:0]  tw_reg_ff;
   logic [4:0]  th_reg_ff;
   logic [10:0] iw_reg_ff;
   logic [15:0] ih_reg_ff;

   logic [TDW-1:0] tw;
   logic [THW-1:0] th;
   logic [IWW-1:0] iw;
   logic [15:0]    ih;

   always_comb begin
      if (tw_reg_ff < 5'd2) begin
         tw = TDW'(2);
      end else if (32'(tw_reg_ff) > MAX_TEMPLATE_W) begin
         tw = TDW'(MAX_TEMPLATE_W);
      end else begin
         tw = TDW'(tw_reg_ff);
      end
      if (th_reg_ff < 5'd2) begin
         th = THW'(2);
      end else if (32'(th_reg_ff) > MAX_TEMPLATE_H) begin
         th = THW'(MAX_TEMPLATE_H);
      end else begin
         th = THW'(th_reg_ff);
      end
      if (iw_reg_ff < 11'd2) begin
         iw = IWW'(2);
      end else if (32'(iw_reg_ff) > MAX_IMAGE_W) begin
         iw = IWW'(MAX_IMAGE_W);
      end else begin
         iw = IWW'(iw_reg_ff);
      end
      if (ih_reg_ff < 16'd2) begin
         ih = 16'd2;
      end else begin
         ih = ih_reg_ff;
      end
   end

   // Control state.
   gcc_pkg::state_type state_ff, state_in;

   logic [TRW-1:0] tc_row_ff;
   logic [TCW-1:0] tc_col_ff;
   logic [ICW-1:0] im_col_ff;
   logic [15:0]    im_row_ff;
   logic [TRW-1:0] im_slot_ff;

   logic [TRW-1:0] sc_row_ff;
   logic [TCW-1:0] sc_col_ff;
   logic [TRW-1:0] sc_slot_ff;
   logic [ICW-1:0] col_base_ff;
   logic [ICW-1:0] ox_ff;
   logic [15:0]    oy_ff;
   logic           flast_ff;

   logic           rsp_valid_ff;
   logic signed [gcc_pkg::CORR_W-1:0] corr_ff;
   logic [9:0]     rsp_ox_ff;
   logic [15:0]    rsp_oy_ff;
   logic           rsp_fl_ff;

   logic accept;
   logic tpl_accept;
   logic img_accept;
   logic fits;
   logic issue;
   logic issue_last;
   logic rsp_free;
   logic start;
   logic load_rsp;
   int   start_slot;

   gcc_pkg::mac_out_type mac_out;

   assign req_if.ready = (state_ff == gcc_pkg::ST_IDLE);
   assign accept       = req_if.valid && req_if.ready;
   assign tpl_accept   = accept && !req_if.req_type;
   assign img_accept   = accept && req_if.req_type;
   assign fits         = (32'(im_row_ff) + 1 >= 32'(th)) && (32'(im_col_ff) + 1 >= 32'(tw));
   assign start        = img_accept && fits;
   assign issue        = (state_ff == gcc_pkg::ST_SCAN);
   assign issue_last   = (32'(sc_row_ff) + 1 >= 32'(th)) && (32'(sc_col_ff) + 1 >= 32'(tw));
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // The window's top row lives th-1 slots behind the current row in the line ring.
   always_comb begin
      start_slot = 32'(im_slot_ff) + MAX_TEMPLATE_H - (32'(th) - 1);
      if (start_slot >= MAX_TEMPLATE_H) begin
         start_slot = start_slot - MAX_TEMPLATE_H;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      load_rsp = 1'b0;
      case (state_ff)
         gcc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = gcc_pkg::ST_SCAN;
            end
         end
         gcc_pkg::ST_SCAN: begin
            if (issue_last) begin
               state_in = gcc_pkg::ST_DRAIN;
            end
         end
         gcc_pkg::ST_DRAIN: begin
            if (mac_out.done) begin
               state_in = gcc_pkg::ST_OUT;
            end
         end
         gcc_pkg::ST_OUT: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = gcc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gcc_pkg::ST_IDLE;
         end
      endcase
   end

   // Configuration writes and the raster counters.  Any register write restarts
   // the template load and the image raster.
   always_ff @(posedge clock) begin
      if (reset) begin
         tw_reg_ff  <= 5'd8;
         th_reg_ff  <= 5'd8;
         iw_reg_ff  <= 11'd640;
         ih_reg_ff  <= 16'd480;
         tc_row_ff  <= '0;
         tc_col_ff  <= '0;
         im_col_ff  <= '0;
         im_row_ff  <= '0;
         im_slot_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            gcc_pkg::CSR_TPL_WIDTH:  tw_reg_ff <= csr_wdata[4:0];
            gcc_pkg::CSR_TPL_HEIGHT: th_reg_ff <= csr_wdata[4:0];
            gcc_pkg::CSR_IMG_WIDTH:  iw_reg_ff <= csr_wdata[10:0];
            gcc_pkg::CSR_IMG_HEIGHT: ih_reg_ff <= csr_wdata;
            default: ;
         endcase
         tc_row_ff  <= '0;
         tc_col_ff  <= '0;
         im_col_ff  <= '0;
         im_row_ff  <= '0;
         im_slot_ff <= '0;
      end else begin
         if (tpl_accept) begin
            if (32'(tc_col_ff) + 1 >= 32'(tw)) begin
               tc_col_ff <= '0;
               if (32'(tc_row_ff) + 1 >= 32'(th)) begin
                  tc_row_ff <= '0;
               end else begin
                  tc_row_ff <= tc_row_ff + 1'b1;
               end
            end else begin
               tc_col_ff <= tc_col_ff + 1'b1;
            end
         end
         if (img_accept) begin
            if (32'(im_col_ff) + 1 >= 32'(iw)) begin
               im_col_ff <= '0;
               if (32'(im_row_ff) + 1 >= 32'(ih)) begin
                  im_row_ff  <= '0;
                  im_slot_ff <= '0;
               end else begin
                  im_row_ff <= im_row_ff + 1'b1;
                  if (32'(im_slot_ff) == MAX_TEMPLATE_H - 1) begin
                     im_slot_ff <= '0;
                  end else begin
                     im_slot_ff <= im_slot_ff + 1'b1;
                  end
               end
            end else begin
               im_col_ff <= im_col_ff + 1'b1;
            end
         end
      end
   end

   // Scan counters walk the template in raster order, one sample per cycle.
   always_ff @(posedge clock) begin
      if (start) begin
         sc_row_ff   <= '0;
         sc_col_ff   <= '0;
         sc_slot_ff  <= TRW'(start_slot);
         col_base_ff <= ICW'(32'(im_col_ff) + 1 - 32'(tw));
         ox_ff       <= ICW'(32'(im_col_ff) + 1 - 32'(tw));
         oy_ff       <= 16'(32'(im_row_ff) + 1 - 32'(th));
         flast_ff    <= (32'(im_row_ff) + 1 == 32'(ih)) && (32'(im_col_ff) + 1 == 32'(iw));
      end else if (issue) begin
         if (32'(sc_col_ff) + 1 >= 32'(tw)) begin
            sc_col_ff <= '0;
            sc_row_ff <= sc_row_ff + 1'b1;
            if (32'(sc_slot_ff) == MAX_TEMPLATE_H - 1) begin
               sc_slot_ff <= '0;
            end else begin
               sc_slot_ff <= sc_slot_ff + 1'b1;
            end
         end else begin
            sc_col_ff <= sc_col_ff + 1'b1;
         end
      end
   end

   // Template and line memories, one write and one registered read each.
   gcc_pkg::pix_type tpl_mem [MAX_TEMPLATE_W * MAX_TEMPLATE_H];
   gcc_pkg::pix_type img_mem [MAX_TEMPLATE_H * MAX_IMAGE_W];
   gcc_pkg::pix_type tpl_rd_ff;
   gcc_pkg::pix_type img_rd_ff;
   logic [TAW-1:0]   tpl_wr_addr;
   logic [TAW-1:0]   tpl_rd_addr;
   logic [IAW-1:0]   img_wr_addr;
   logic [IAW-1:0]   img_rd_addr;

   assign tpl_wr_addr = TAW'(32'(tc_row_ff) * MAX_TEMPLATE_W + 32'(tc_col_ff));
   assign tpl_rd_addr = TAW'(32'(sc_row_ff) * MAX_TEMPLATE_W + 32'(sc_col_ff));
   assign img_wr_addr = IAW'(32'(im_slot_ff) * MAX_IMAGE_W + 32'(im_col_ff));
   assign img_rd_addr = IAW'(32'(sc_slot_ff) * MAX_IMAGE_W + 32'(col_base_ff)
                             + 32'(sc_col_ff));

   always_ff @(posedge clock) begin
      if (tpl_accept) begin
         tpl_mem[tpl_wr_addr] <= req_if.pixel_value;
      end
      tpl_rd_ff <= tpl_mem[tpl_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (img_accept) begin
         img_mem[img_wr_addr] <= req_if.pixel_value;
      end
      img_rd_ff <= img_mem[img_rd_addr];
   end

   // Tags that travel with the read data.
   logic rd_valid_ff;
   logic rd_first_row_ff;
   logic rd_first_col_ff;
   logic rd_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_row_ff <= (sc_row_ff == '0);
      rd_first_col_ff <= (sc_col_ff == '0);
      rd_last_ff      <= issue_last;
   end

   // The cell chain delays each sample pair by one template row, so the tap at
   // position tw-1 holds the pair directly above, and cell zero the pair to the left.
   gcc_pkg::pair_type cell_q [MAX_TEMPLATE_W];
   gcc_pkg::pair_type head;

   assign head.tpl = tpl_rd_ff;
   assign head.img = img_rd_ff;

   for (genvar k = 0; k < MAX_TEMPLATE_W; k++) begin : g_cells
      if (k == 0) begin : g_head
         gcc_cell u_cell (.clock(clock), .shift(rd_valid_ff), .d(head), .q(cell_q[k]));
      end else begin : g_body
         gcc_cell u_cell (.clock(clock), .shift(rd_valid_ff), .d(cell_q[k-1]), .q(cell_q[k]));
      end
   end

   gcc_pkg::pair_type        left;
   gcc_pkg::pair_type        up;
   gcc_pkg::grad_bundle_type grad;

   assign left = cell_q[0];
   assign up   = cell_q[TCW'(32'(tw) - 1)];

   always_comb begin
      grad.valid = rd_valid_ff;
      grad.last  = rd_last_ff;
      if (rd_first_col_ff) begin
         grad.dx_t = '0;
         grad.dx_i = '0;
      end else begin
         grad.dx_t = gcc_pkg::grad_type'(head.tpl) - gcc_pkg::grad_type'(left.tpl);
         grad.dx_i = gcc_pkg::grad_type'(head.img) - gcc_pkg::grad_type'(left.img);
      end
      if (rd_first_row_ff) begin
         grad.dy_t = '0;
         grad.dy_i = '0;
      end else begin
         grad.dy_t = gcc_pkg::grad_type'(head.tpl) - gcc_pkg::grad_type'(up.tpl);
         grad.dy_i = gcc_pkg::grad_type'(head.img) - gcc_pkg::grad_type'(up.img);
      end
   end

   gcc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (start),
      .grad   (grad),
      .result (mac_out)
   );

   // Output register: holds one result while the next request is being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         corr_ff   <= mac_out.sum;
         rsp_ox_ff <= 10'(ox_ff);
         rsp_oy_ff <= oy_ff;
         rsp_fl_ff <= flast_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.correlation = corr_ff;
   assign rsp_if.offset_x    = rsp_ox_ff;
   assign rsp_if.offset_y    = rsp_oy_ff;
   assign rsp_if.frame_last  = rsp_fl_ff;

   // The accumulator finishes only while the controller waits for it.
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_out.done |-> state_ff == gcc_pkg::ST_DRAIN)
      else $error("accumulator finished outside the drain phase");

   // A new result is loaded only from the output state.
   a_load_from_out: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> rsp_free && state_ff == gcc_pkg::ST_OUT)
      else $error("result loaded while the output register was busy");

   // The scan never walks past the last template row.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == gcc_pkg::ST_SCAN |-> 32'(sc_row_ff) < 32'(th))
      else $error("scan row beyond template height");

   // Read data only flows during a scan or its drain.
   a_read_window: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == gcc_pkg::ST_SCAN || state_ff == gcc_pkg::ST_DRAIN))
      else $error("memory read data outside a scan");

endmodule
